FILE: sv/ksls_pkg.sv
package ksls_pkg;

  localparam int WORD_W = 32;
  localparam int RANK_W = 9;

  typedef enum logic [1:0] {
    KIND_LOAD  = 2'd0,
    KIND_QUERY = 2'd1,
    KIND_CLEAR = 2'd2
  } kind_t;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_INS  = 5'b00010,
    S_FIN  = 5'b00100,
    S_QL   = 5'b01000,
    S_QG   = 5'b10000
  } state_t;

endpackage

FILE: sv/ksls_in_if.sv
interface ksls_in_if import ksls_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [1:0]               kind;
  logic signed [WORD_W-1:0] value;
  logic [RANK_W-1:0]        rank_least;
  logic [RANK_W-1:0]        rank_largest;

  modport source (output valid, kind, value, rank_least, rank_largest, input ready);
  modport sink (input valid, kind, value, rank_least, rank_largest, output ready);
endinterface

FILE: sv/ksls_out_if.sv
interface ksls_out_if import ksls_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [WORD_W-1:0] least_value;
  logic signed [WORD_W-1:0] largest_value;
  logic                     least_rank_bad;
  logic                     largest_rank_bad;
  logic                     overflowed;

  modport source (output valid, least_value, largest_value, least_rank_bad,
                  largest_rank_bad, overflowed, input ready);
  modport sink (input valid, least_value, largest_value, least_rank_bad,
                largest_rank_bad, overflowed, output ready);
endinterface

FILE: sv/kth_smallest_largest_select_top.sv
// Order-statistic store: holds up to MAX_ITEMS signed 32-bit numbers in
// ascending order in a single-port-write, registered-read memory. A load
// inserts at the sorted place by shifting larger entries up one per cycle;
// a load into a full set only sets the overflow flag, one into an empty set
// is written straight to the first entry. A query reads two entries through
// the one read port in turn; a clear empties the set and resets the overflow
// flag. One item is worked on at a time; a finished query result
// sits in an output register so the next item can be taken while it waits.
// Ranks outside 1..count give a zero value with the matching error flag.
module kth_smallest_largest_select_top import ksls_pkg::*; #(
  parameter int MAX_ITEMS = 256
) (
  input logic       clk,
  input logic       rst,
  ksls_in_if.sink   in_ch,
  ksls_out_if.source out_ch
);

  localparam int AW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
  localparam int CW = $clog2(MAX_ITEMS + 1);
  localparam int XW = (CW > RANK_W) ? CW : RANK_W;

  state_t                   state;
  logic [CW-1:0]            cnt;
  logic                     ovf;
  logic [AW-1:0]            pos;
  logic signed [WORD_W-1:0] ins_val;
  logic [AW-1:0]            rg_addr;
  logic                     rl_ok;
  logic                     rg_ok;
  logic signed [WORD_W-1:0] least;

  logic                     out_valid;
  logic signed [WORD_W-1:0] out_least;
  logic signed [WORD_W-1:0] out_largest;
  logic                     out_lbad;
  logic                     out_gbad;
  logic                     out_ovf;

  logic                     we;
  logic [AW-1:0]            waddr;
  logic signed [WORD_W-1:0] wdata;
  logic [AW-1:0]            raddr;
  logic signed [WORD_W-1:0] rdata;

  logic          accept;
  logic [XW-1:0] cnt_x;
  logic [XW-1:0] rl_x;
  logic [XW-1:0] rg_x;
  logic          rl_ok_in;
  logic          rg_ok_in;
  logic          full;
  logic          shift;
  logic          out_load;

  assign accept   = in_ch.valid && in_ch.ready;
  assign cnt_x    = XW'(cnt);
  assign rl_x     = XW'(in_ch.rank_least);
  assign rg_x     = XW'(in_ch.rank_largest);
  assign rl_ok_in = (rl_x != '0) && (rl_x <= cnt_x);
  assign rg_ok_in = (rg_x != '0) && (rg_x <= cnt_x);
  assign full     = (cnt_x >= XW'(MAX_ITEMS));
  assign shift    = (ins_val < rdata);
  assign out_load = (state == S_QG) && (!out_valid || out_ch.ready);

  assign in_ch.ready = (state == S_IDLE);

  ksls_store #(.DEPTH(MAX_ITEMS), .AW(AW)) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_comb begin
    we    = 1'b0;
    waddr = pos;
    wdata = ins_val;
    raddr = rg_addr;
    unique case (state)
      S_IDLE: begin
        if (in_ch.kind == KIND_LOAD) begin
          raddr = AW'(cnt - CW'(1));
          we    = accept && (cnt == '0);
          waddr = '0;
          wdata = in_ch.value;
        end else begin
          raddr = AW'(rl_x - XW'(1));
        end
      end
      S_INS: begin
        raddr = pos - AW'(2);
        we    = 1'b1;
        waddr = pos;
        wdata = shift ? rdata : ins_val;
      end
      S_FIN: begin
        we    = 1'b1;
        waddr = '0;
        wdata = ins_val;
      end
      S_QL, S_QG: begin
        raddr = rg_addr;
      end
      default: begin
        raddr = rg_addr;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
      ovf   <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            unique case (in_ch.kind)
              KIND_LOAD: begin
                if (full) begin
                  ovf <= 1'b1;
                end else if (cnt == '0) begin
                  cnt <= cnt + CW'(1);
                end else begin
                  state <= S_INS;
                end
              end
              KIND_QUERY: state <= S_QL;
              KIND_CLEAR: begin
                cnt <= '0;
                ovf <= 1'b0;
              end
              default: state <= S_IDLE;
            endcase
          end
        end
        S_INS: begin
          if (!shift) begin
            cnt   <= cnt + CW'(1);
            state <= S_IDLE;
          end else if (pos == AW'(1)) begin
            state <= S_FIN;
          end
        end
        S_FIN: begin
          cnt   <= cnt + CW'(1);
          state <= S_IDLE;
        end
        S_QL: state <= S_QG;
        S_QG: begin
          if (out_load) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE) begin
      pos     <= AW'(cnt);
      ins_val <= in_ch.value;
      rg_addr <= AW'(cnt_x - rg_x);
      rl_ok   <= rl_ok_in;
      rg_ok   <= rg_ok_in;
    end else if (state == S_INS) begin
      pos <= pos - AW'(1);
    end
    if (state == S_QL) begin
      least <= rl_ok ? rdata : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_least   <= least;
      out_largest <= rg_ok ? rdata : '0;
      out_lbad    <= !rl_ok;
      out_gbad    <= !rg_ok;
      out_ovf     <= ovf;
    end
  end

  assign out_ch.valid            = out_valid;
  assign out_ch.least_value      = out_least;
  assign out_ch.largest_value    = out_largest;
  assign out_ch.least_rank_bad   = out_lbad;
  assign out_ch.largest_rank_bad = out_gbad;
  assign out_ch.overflowed       = out_ovf;

endmodule

FILE: sv/ksls_store.sv
module ksls_store import ksls_pkg::*; #(
  parameter int DEPTH = 256,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [AW-1:0]            waddr,
  input  logic signed [WORD_W-1:0] wdata,
  input  logic [AW-1:0]            raddr,
  output logic signed [WORD_W-1:0] rdata
);

  logic signed [WORD_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule
